// ===== rtl/core/fsip_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer printer package
// Shared types, character codes and digit tables for the integer printer.
// ----------------------------------------------------------------------------
package fsip_pkg;

   // ASCII codes the classifier and the number unit act on
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_D       = 8'h64;
   localparam logic [7:0] CHAR_U       = 8'h75;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;
   localparam logic [7:0] CHAR_C       = 8'h63;
   localparam logic [7:0] CHAR_S       = 8'h73;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_HEX_A   = 8'h37;  // 'A' - 10

   // command queue between classifier and number unit
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // number of decimal digits of a 32-bit magnitude
   localparam int DEC_DIGITS = 10;

   typedef struct packed {
      logic [7:0]  fmt_char;
      logic [31:0] arg_value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // one classified item: either a single character or a number to print
   typedef struct packed {
      logic        is_num;
      logic        hex;
      logic        minus;
      logic [31:0] value;   // magnitude, or the character in the low byte
   } cmd_type;

   function automatic logic [33:0] pow10(input logic [3:0] p);
      logic [33:0] r;
      unique case (p)
         4'd0:    r = 34'd1;
         4'd1:    r = 34'd10;
         4'd2:    r = 34'd100;
         4'd3:    r = 34'd1000;
         4'd4:    r = 34'd10000;
         4'd5:    r = 34'd100000;
         4'd6:    r = 34'd1000000;
         4'd7:    r = 34'd10000000;
         4'd8:    r = 34'd100000000;
         4'd9:    r = 34'd1000000000;
         default: r = 34'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] r;
      if (d < 4'd10) r = CHAR_ZERO + {4'd0, d};
      else           r = CHAR_HEX_A + {4'd0, d};
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/format_string_integer_printer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer printer
// printf-style formatter for d, u, X and c directives over a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one format character plus argument word per transfer.
//    Literal characters echo; '%' arms a directive; NUL emits nothing.
//  - rsp channel: one ASCII byte per transfer; last marks the final byte of
//    the item that caused it.
//  - csr port: csr_wr_en writes bit 0 (32-bit / 16-bit integers). Write only
//    while the block is idle.
//  - Timing: a literal byte passes through the command queue into the output
//    register. A number is first loaded into the number unit, which then
//    emits one character per cycle (sign plus up to ten digits) while the
//    output register is free.
//  - A two-entry command queue sits between the classifier and the number
//    unit, so new items are taken while a number is still being printed.
//  - When the receiver stalls, the output register holds its byte and the
//    queue fills; req_ready drops only once the queue is full.
//  - Reset clears the pending percent flag, the queue and the output, and
//    sets 32-bit mode.
// ----------------------------------------------------------------------------
module format_string_integer_printer (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_wr_en,
   input  wire                   csr_wr_data,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  fsip_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output fsip_pkg::rsp_type     rsp_data
);

   // integer width select, reset to 32-bit
   logic int_is_32bit_ff;

   // classifier to queue
   logic              push;
   fsip_pkg::cmd_type push_cmd;
   logic              queue_full;

   // queue to number unit
   logic              pop;
   logic              head_valid;
   fsip_pkg::cmd_type head_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         int_is_32bit_ff <= 1'b1;
      end else if (csr_wr_en) begin
         int_is_32bit_ff <= csr_wr_data;
      end
   end

   fsip_front u_front (
      .clock        (clock),
      .reset        (reset),
      .int_is_32bit (int_is_32bit_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .queue_full   (queue_full),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   fsip_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // number unit also owns the output register
   fsip_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

// ===== rtl/core/fsip_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Format classifier
// Accepts format characters, tracks the pending percent sign and turns each
// printing item into a character or number command for the queue.
// ----------------------------------------------------------------------------
module fsip_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   int_is_32bit,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  fsip_pkg::req_type     req_data,
   input  wire                   queue_full,
   output logic                  push,
   output fsip_pkg::cmd_type     push_cmd
);

   logic        pending_ff;
   logic        pending_in;
   logic        accept;
   logic        want_push;
   logic [7:0]  ch;
   logic [31:0] arg;
   logic        neg;
   logic [31:0] mag;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && want_push;
   assign ch        = req_data.fmt_char;
   assign arg       = req_data.arg_value;

   // magnitude within the selected integer width
   always_comb begin
      if (int_is_32bit) begin
         neg = (ch == fsip_pkg::CHAR_D) && arg[31];
         mag = neg ? (32'd0 - arg) : arg;
      end else begin
         neg = (ch == fsip_pkg::CHAR_D) && arg[15];
         mag = neg ? {16'd0, 16'd0 - arg[15:0]} : {16'd0, arg[15:0]};
      end
   end

   always_comb begin
      pending_in = pending_ff;
      want_push  = 1'b0;
      push_cmd   = '{is_num: 1'b0, hex: 1'b0, minus: 1'b0, value: {24'd0, ch}};
      if (!pending_ff) begin
         if (ch == fsip_pkg::CHAR_PERCENT) begin
            pending_in = 1'b1;
         end else if (ch != fsip_pkg::CHAR_NUL) begin
            want_push = 1'b1;
         end
      end else begin
         pending_in = 1'b0;
         if (ch == fsip_pkg::CHAR_D || ch == fsip_pkg::CHAR_U ||
             ch == fsip_pkg::CHAR_UPPER_X) begin
            want_push = 1'b1;
            push_cmd  = '{is_num: 1'b1, hex: (ch == fsip_pkg::CHAR_UPPER_X),
                          minus: neg, value: mag};
         end else if (ch == fsip_pkg::CHAR_C) begin
            want_push      = 1'b1;
            push_cmd.value = {24'd0, arg[7:0]};
         end else if (ch != fsip_pkg::CHAR_S && ch != fsip_pkg::CHAR_NUL) begin
            want_push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else if (accept) begin
         pending_ff <= pending_in;
      end
   end

   a_percent_arms: assert property (@(posedge clock) disable iff (reset)
      (accept && !pending_ff && ch == fsip_pkg::CHAR_PERCENT) |=> pending_ff)
      else $error("percent sign did not arm the pending flag");

endmodule
`default_nettype wire

// ===== rtl/core/fsip_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO of classified commands between classifier and number unit.
// ----------------------------------------------------------------------------
module fsip_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  fsip_pkg::cmd_type     push_cmd,
   output logic                  full,
   input  wire                   pop,
   output logic                  head_valid,
   output fsip_pkg::cmd_type     head_cmd
);

   fsip_pkg::cmd_type                   entry_ff [fsip_pkg::QUEUE_DEPTH];
   logic [fsip_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff;
   logic [fsip_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff;
   logic [fsip_pkg::QUEUE_CNT_W-1:0]    count_ff;
   logic [fsip_pkg::QUEUE_CNT_W-1:0]    count_in;
   logic                                do_pop;

   assign full       = (count_ff == fsip_pkg::QUEUE_CNT_W'(fsip_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop)      count_in = count_ff + 1'b1;
      else if (!push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push)   wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fsip_pkg::QUEUE_CNT_W'(fsip_pkg::QUEUE_DEPTH))
      else $error("command queue overflow");

endmodule
`default_nettype wire

// ===== rtl/core/fsip_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Number unit
// Takes commands from the queue and emits characters one per cycle into the
// free output register: single characters directly, numbers digit by digit.
// ----------------------------------------------------------------------------
module fsip_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   head_valid,
   input  fsip_pkg::cmd_type     head_cmd,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output fsip_pkg::rsp_type     rsp_data
);

   logic                 busy_ff,  busy_in;
   logic                 hex_ff,   hex_in;
   logic                 minus_ff, minus_in;
   logic [31:0]          val_ff,   val_in;
   logic [3:0]           pos_ff,   pos_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   fsip_pkg::rsp_type    rsp_ff,   rsp_in;

   logic                 out_free;
   logic [33:0]          place;
   logic [33:0]          mult [10];
   logic [3:0]           dec_digit;
   logic [3:0]           hex_digit;
   logic [31:0]          dec_rem;
   logic [3:0]           dec_start;
   logic [2:0]           hex_start;
   logic                 digit_fire;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign digit_fire = busy_ff && out_free && !minus_ff;

   // decimal digit: count of multiples of the place value not above the rest
   always_comb begin
      place     = fsip_pkg::pow10(pos_ff);
      dec_digit = 4'd0;
      mult[0]   = 34'd0;
      for (int k = 1; k < 10; k++) begin
         mult[k] = place * 34'(k);
         if ({2'b00, val_ff} >= mult[k]) dec_digit = dec_digit + 4'd1;
      end
      dec_rem   = 32'(({2'b00, val_ff} - mult[dec_digit]));
      hex_digit = val_ff[{pos_ff[2:0], 2'b00} +: 4];
   end

   // first printed position of a new number (leading zeros skipped)
   always_comb begin
      dec_start = 4'd0;
      hex_start = 3'd0;
      for (int i = 1; i < fsip_pkg::DEC_DIGITS; i++) begin
         if ({2'b00, head_cmd.value} >= fsip_pkg::pow10(4'(i)))
            dec_start = dec_start + 4'd1;
      end
      for (int i = 1; i < 8; i++) begin
         if (head_cmd.value[4*i +: 4] != 4'd0) hex_start = 3'(i);
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      hex_in       = hex_ff;
      minus_in     = minus_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      if (busy_ff) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            if (minus_ff) begin
               rsp_in   = '{out_byte: fsip_pkg::CHAR_MINUS, last: 1'b0};
               minus_in = 1'b0;
            end else begin
               rsp_in = '{out_byte: fsip_pkg::digit_char(hex_ff ? hex_digit : dec_digit),
                          last: (pos_ff == 4'd0)};
               val_in = hex_ff ? val_ff : dec_rem;
               pos_in = pos_ff - 4'd1;
               if (pos_ff == 4'd0) busy_in = 1'b0;
            end
         end
      end else if (head_valid) begin
         if (head_cmd.is_num) begin
            pop      = 1'b1;
            busy_in  = 1'b1;
            hex_in   = head_cmd.hex;
            minus_in = head_cmd.minus;
            val_in   = head_cmd.value;
            pos_in   = head_cmd.hex ? {1'b0, hex_start} : dec_start;
         end else if (out_free) begin
            pop          = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_in       = '{out_byte: head_cmd.value[7:0], last: 1'b1};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hex_ff   <= hex_in;
      minus_ff <= minus_in;
      val_ff   <= val_in;
      pos_ff   <= pos_in;
      rsp_ff   <= rsp_in;
   end

   a_dec_remainder: assert property (@(posedge clock) disable iff (reset)
      (digit_fire && !hex_ff) |-> ({2'b00, dec_rem} < place))
      else $error("decimal digit out of range");

   a_last_digit: assert property (@(posedge clock) disable iff (reset)
      (digit_fire && pos_ff == 4'd0) |=> (rsp_valid_ff && rsp_ff.last && !busy_ff))
      else $error("final digit not marked last");

   a_hex_pos: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && hex_ff) |-> !pos_ff[3])
      else $error("hex digit position beyond word");

endmodule
`default_nettype wire

// ===== verif/fsip_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer printer stream checker
// Watches the request, response and csr ports, renders the expected output
// bytes of every accepted format character and compares them in order.
// ----------------------------------------------------------------------------
module fsip_stream_checker
   import fsip_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     csr_wr_en,
   input  wire     csr_wr_data,
   input  wire     req_valid,
   input  wire     req_ready,
   input  req_type req_data,
   input  wire     rsp_valid,
   input  wire     rsp_ready,
   input  rsp_type rsp_data,
   output int      pending_results,
   output int      mismatch_count,
   output int      results_checked
);

   localparam int REPORT_LIMIT = 10;
   localparam logic [8*16-1:0] DIGIT_GLYPHS = "0123456789ABCDEF";

   rsp_type expected_chars[$];
   logic    directive_armed;
   logic    wide_ints;
   int      errors;
   int      checked;

   // expected bytes of one format character, appended to expected_chars
   task automatic render_item(input logic [7:0] ch, input logic [31:0] arg);
      rsp_type     chars[$];
      logic [31:0] mag;
      logic [31:0] place;
      logic [31:0] base;
      logic [3:0]  digit;
      if (!directive_armed) begin
         if (ch == CHAR_PERCENT) directive_armed = 1'b1;
         else if (ch != CHAR_NUL) chars.push_back('{out_byte: ch, last: 1'b0});
      end else begin
         directive_armed = 1'b0;
         case (ch)
            CHAR_D, CHAR_U, CHAR_UPPER_X: begin
               mag = wide_ints ? arg : {16'h0, arg[15:0]};
               if (ch == CHAR_D && (wide_ints ? mag[31] : mag[15])) begin
                  // negation wraps inside the integer width
                  mag = 32'd0 - mag;
                  if (!wide_ints) mag[31:16] = 16'h0;
                  chars.push_back('{out_byte: CHAR_MINUS, last: 1'b0});
               end
               if (ch == CHAR_UPPER_X) begin
                  base  = 32'd16;
                  place = wide_ints ? 32'h1000_0000 : 32'h1000;
               end else begin
                  base  = 32'd10;
                  place = wide_ints ? 32'd1_000_000_000 : 32'd10_000;
               end
               // drop leading zeros, keep one digit for zero
               while (place > 32'd1 && place > mag) place = place / base;
               while (place != 32'd0) begin
                  digit = 4'(mag / place);
                  chars.push_back('{out_byte: DIGIT_GLYPHS[8*(15-digit) +: 8], last: 1'b0});
                  mag   = mag % place;
                  place = place / base;
               end
            end
            CHAR_C:             chars.push_back('{out_byte: arg[7:0], last: 1'b0});
            CHAR_S, CHAR_NUL:   ;
            default:            chars.push_back('{out_byte: ch, last: 1'b0});
         endcase
      end
      if (chars.size() > 0) chars[chars.size()-1].last = 1'b1;
      foreach (chars[i]) expected_chars.push_back(chars[i]);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         directive_armed = 1'b0;
         wide_ints       = 1'b1;
         expected_chars.delete();
      end else begin
         if (csr_wr_en) wide_ints = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_chars.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%0t: unexpected byte %h last %b", $realtime,
                           rsp_data.out_byte, rsp_data.last);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.out_byte !== want.out_byte || rsp_data.last !== want.last) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("%0t: byte %h last %b, expected byte %h last %b", $realtime,
                              rsp_data.out_byte, rsp_data.last, want.out_byte, want.last);
               end
            end
         end
         if (req_valid && req_ready) render_item(req_data.fmt_char, req_data.arg_value);
      end
      pending_results <= expected_chars.size();
      mismatch_count  <= errors;
      results_checked <= checked;
   end

endmodule

// ===== verif/format_string_integer_printer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer printer testbench
// Feeds format characters and arguments to the printer in 16-bit and 32-bit
// modes with random idle cycles on both sides and one long output stall;
// a stream checker beside the block predicts and compares every byte.
// ----------------------------------------------------------------------------
module format_string_integer_printer_tb;
   import fsip_pkg::*;

   localparam int PHASE_ITEMS  = 120;      // random format characters per csr setting
   localparam int QUIET_CYCLES = 16;       // wait after the last predicted byte, covers silent items
   localparam int LONG_HOLD    = 400;      // receiver hold-off, fills the command queue
   localparam int CYCLE_LIMIT  = 200_000;  // hard stop for the cycle counter below

   logic    clock;
   logic    reset;
   logic    csr_wr_en;
   logic    csr_wr_data;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int   pending_results;
   int   mismatch_count;
   int   results_checked;
   int   items_sent;
   int   bytes_taken;
   int   cycle_count;
   logic rsp_hold;
   logic input_backpressured;

   format_string_integer_printer dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // prediction and comparison live in the checker; the top only drives
   fsip_stream_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .pending_results (pending_results),
      .mismatch_count  (mismatch_count),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop in case the block hangs or drops bytes
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Request side
   // --------------------------------------------------------------------------

   // One request transfer. valid is only lowered when a gap is drawn, so a
   // back-to-back transfer keeps it high with a single assignment per step.
   // Every 64 items the first 16 go out with no gaps at all, and none while
   // the receiver is held off, so the queue really fills.
   task automatic send_item(input logic [7:0] ch, input logic [31:0] arg);
      int gap;
      gap = (items_sent % 64 < 16 || rsp_hold) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{fmt_char: ch, arg_value: arg};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Drop valid, wait for every predicted byte, then let silent items
   // (bare percent, NUL, %s) clear the pipe.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_width(input logic wide);
      settle();
      csr_wr_data <= wide;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // argument mix: small values, sign boundaries of both widths, full random
   function automatic logic [31:0] pick_arg();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 5))
         0: r = $urandom_range(0, 20);
         1: case ($urandom_range(0, 3))
               0: r = 32'h0000_0000;
               1: r = 32'h8000_0000;
               2: r = 32'hFFFF_FFFF;
               default: r = 32'h7FFF_FFFF;
            endcase
         2: case ($urandom_range(0, 2))
               0: r[15:0] = 16'h8000;
               1: r[15:0] = 16'h7FFF;
               default: r[15:0] = 16'hFFFF;
            endcase
         default: ;
      endcase
      return r;
   endfunction

   // One random unit: mostly a complete directive, some literal text, and a
   // share of broken or odd sequences.
   task automatic send_random_unit();
      int          pick;
      logic [7:0]  conv;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         case ($urandom_range(0, 3))
            0: conv = CHAR_D;
            1: conv = CHAR_U;
            2: conv = CHAR_UPPER_X;
            default: conv = CHAR_C;
         endcase
         send_item(CHAR_PERCENT, $urandom);
         send_item(conv, pick_arg());
      end else if (pick < 85) begin
         send_item(8'($urandom_range(0, 255)), $urandom);
      end else if (pick < 90) begin
         send_item(CHAR_NUL, $urandom);
      end else begin
         send_item(CHAR_PERCENT, $urandom);
         case ($urandom_range(0, 3))
            0: send_item(CHAR_PERCENT, $urandom);
            1: send_item(CHAR_S, $urandom);
            2: send_item(CHAR_NUL, $urandom);
            default: send_item(8'($urandom_range(0, 255)), pick_arg());
         endcase
      end
   endtask

   // --------------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------------
   initial begin
      int target;
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 1'b0;
      req_valid   <= 1'b0;
      req_data    <= '0;
      items_sent  = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed, reset width (32-bit)
      send_item(8'h41, 32'h0);                      // plain 'A'
      send_item(8'hFF, 32'hFFFF_FFFF);              // top byte value as literal
      send_item(CHAR_NUL, 32'h1234_5678);           // NUL with nothing pending
      send_item(CHAR_PERCENT, 32'h0);
      send_item(CHAR_D, 32'h8000_0000);             // most negative 32-bit
      send_item(CHAR_PERCENT, 32'h0);
      send_item(CHAR_D, 32'hFFFF_FFFF);             // -1
      send_item(CHAR_PERCENT, 32'h0);
      send_item(CHAR_U, 32'hFFFF_FFFF);             // widest decimal
      send_item(CHAR_PERCENT, 32'h0);
      send_item(CHAR_UPPER_X, 32'h0);               // zero prints one digit
      send_item(CHAR_PERCENT, 32'h0);
      send_item(CHAR_C, 32'h1234_5641);             // low byte only
      send_item(CHAR_PERCENT, 32'h0);
      send_item(CHAR_PERCENT, 32'h0);               // escaped percent
      send_item(CHAR_PERCENT, 32'h0);
      send_item(CHAR_S, 32'h0);                     // string directive is silent
      send_item(CHAR_PERCENT, 32'h0);
      send_item(CHAR_NUL, 32'h0);                   // NUL ends a pending directive

      // directed, 16-bit width: upper half ignored
      write_width(1'b0);
      send_item(CHAR_PERCENT, 32'h0);
      send_item(CHAR_D, 32'h1234_8000);             // -32768
      send_item(CHAR_PERCENT, 32'h0);
      send_item(CHAR_U, 32'hFFFF_FFFF);             // 65535
      send_item(CHAR_PERCENT, 32'h0);
      send_item(CHAR_UPPER_X, 32'hABCD_F00D);

      // random phases, alternating width, both extremes rewritten
      for (int phase = 0; phase < 4; phase++) begin
         write_width(phase % 2 == 0);
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) send_random_unit();
      end

      settle();
      $display("Sent %0d format characters in 16-bit and 32-bit modes, checked %0d bytes.",
               items_sent, results_checked);
      $display("Long output stall %s the request side.",
               input_backpressured ? "back-pressured" : "did not back-pressure");
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // --------------------------------------------------------------------------
   // Response side
   // --------------------------------------------------------------------------

   // random stall before each byte, with stall-free stretches
   initial begin
      int stall;
      rsp_ready   <= 1'b0;
      bytes_taken = 0;
      @(posedge clock);
      forever begin
         stall = (bytes_taken % 48 < 12) ? 0 : $urandom_range(0, 3);
         if (stall > 0 || rsp_hold) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
            while (rsp_hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         bytes_taken++;
      end
   end

   // one long hold-off in the middle of the random part
   initial begin
      rsp_hold            <= 1'b0;
      input_backpressured <= 1'b0;
      wait (items_sent >= 200);
      @(posedge clock);
      rsp_hold <= 1'b1;
      for (int n = 0; n < LONG_HOLD; n++) begin
         @(posedge clock);
         if (req_valid && !req_ready) input_backpressured <= 1'b1;
      end
      rsp_hold <= 1'b0;
   end

endmodule

// ===== sim.f =====
rtl/core/fsip_pkg.sv
rtl/core/fsip_front.sv
rtl/core/fsip_queue.sv
rtl/core/fsip_back.sv
rtl/core/format_string_integer_printer.sv
verif/fsip_stream_checker.sv
verif/format_string_integer_printer_tb.sv
